>>> sv/stff_pkg.sv
package stff_pkg;

    typedef enum logic [2:0] {
        MODE_INSERT,
        MODE_WRITE,
        MODE_CHANGE,
        MODE_REMOVE,
        MODE_READ,
        MODE_FIND,
        MODE_RESIZE,
        MODE_CLEAR
    } t_mode;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_RANGE     = 3'd1;
    localparam logic [2:0] ST_UNUSED    = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    localparam logic [6:0] GROW_STEP_RESET = 7'd1;

    typedef struct packed {
        logic load;
        logic step;
        logic sweep;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic ins_end;
        logic find_end;
        logic sweep_last;
    } t_stat;

endpackage

>>> sv/stff_ctrl.sv
module stff_ctrl
    import stff_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_mode i_mode,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_ONE,
        S_READ,
        S_RDOUT,
        S_FIND,
        S_SWEEP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    case (i_mode)
                        MODE_INSERT: n_state = S_INSERT;
                        MODE_FIND:   n_state = S_FIND;
                        MODE_RESIZE: n_state = S_SWEEP;
                        MODE_READ:   n_state = S_READ;
                        default:     n_state = S_ONE;
                    endcase
                end
            end
            S_INSERT: begin
                if (i_stat.ins_end) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_ONE: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            S_READ: begin
                n_state = S_RDOUT;
            end
            S_RDOUT: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            S_FIND: begin
                if (i_stat.find_end) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_busy = r_busy;

endmodule

>>> sv/stff_dp.sv
module stff_dp
    import stff_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  t_mode       i_mode,
    input  logic [5:0]  i_slot_index,
    input  logic [31:0] i_data_value,
    input  logic [6:0]  i_new_size,
    input  logic        i_cfg_valid,
    input  logic [6:0]  i_cfg_grow_step,
    output logic        o_result_valid,
    output logic [5:0]  o_result_index,
    output logic [31:0] o_read_value,
    output logic        o_slot_was_valid,
    output logic [6:0]  o_used_count,
    output logic [6:0]  o_size_in_use,
    output logic [2:0]  o_status
);

    localparam int IW = $clog2(CAPACITY);
    localparam int SW = $clog2(CAPACITY + 1);
    localparam int CW = (SW > 7) ? SW : 7;
    localparam int GW = CW + 1;
    localparam logic [SW-1:0] CAP_S  = SW'(CAPACITY);
    localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
    localparam logic [GW-1:0] CAP_G  = GW'(CAPACITY);
    localparam logic [SW-1:0] LAST_S = SW'(CAPACITY - 1);

    logic [DATA_WIDTH-1:0] mem [CAPACITY];

    t_mode                 r_mode;
    logic [5:0]            r_idx;
    logic [DATA_WIDTH-1:0] r_data;
    logic [6:0]            r_req;
    logic [6:0]            r_step;
    logic [CAPACITY-1:0]   r_valid;
    logic [SW-1:0]         r_size;
    logic [SW-1:0]         r_count;
    logic [SW-1:0]         r_ctr;
    logic [IW-1:0]         r_cmp_addr;
    logic                  r_cmp_live;
    logic [DATA_WIDTH-1:0] r_rd_data;
    logic                  r_res_valid;
    logic [5:0]            r_res_index;
    logic [31:0]           r_res_value;
    logic                  r_res_was;
    logic [2:0]            r_res_status;

    logic [5:0]            n_res_index;
    logic [31:0]           n_res_value;
    logic                  n_res_was;
    logic [2:0]            n_res_status;

    logic [IW-1:0] ctr_a;
    logic          ctr_in_size;
    logic          ctr_valid;
    logic [CW-1:0] idx_c;
    logic [IW-1:0] idx_a;
    logic          idx_in;
    logic          idx_was;
    logic [CW-1:0] req_c;
    logic [SW-1:0] ns;
    logic [6:0]    step_eff;
    logic [GW-1:0] grown;
    logic [SW-1:0] grown_sat;
    logic          ins_full;
    logic          hit;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [IW-1:0] rd_addr;

    assign ctr_a       = r_ctr[IW-1:0];
    assign ctr_in_size = (r_ctr < r_size);
    assign ctr_valid   = ctr_in_size && r_valid[ctr_a];

    assign idx_c   = CW'(r_idx);
    assign idx_a   = idx_c[IW-1:0];
    assign idx_in  = (idx_c < CW'(r_size));
    assign idx_was = idx_in && r_valid[idx_a];

    assign req_c = CW'(r_req);
    assign ns    = (req_c > CAP_C) ? CAP_S : SW'(req_c);

    assign step_eff  = (r_step == 7'd0) ? 7'd1 : r_step;
    assign grown     = GW'(r_size) + GW'(step_eff);
    assign grown_sat = (grown > CAP_G) ? CAP_S : SW'(grown);
    assign ins_full  = !ctr_in_size && (r_size == CAP_S);

    assign hit = r_cmp_live && r_valid[r_cmp_addr] && (r_rd_data == r_data);

    assign o_stat.ins_end    = !ctr_in_size || !ctr_valid;
    assign o_stat.find_end   = hit || !ctr_in_size;
    assign o_stat.sweep_last = (r_ctr == LAST_S);

    assign rd_addr = (r_mode == MODE_READ) ? idx_a : ctr_a;
    assign wr_addr = (r_mode == MODE_INSERT) ? ctr_a : idx_a;
    assign wr_en   = i_cmd.finish
                     && (((r_mode == MODE_INSERT) && !ins_full)
                         || ((r_mode == MODE_WRITE || r_mode == MODE_CHANGE) && idx_in));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= r_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_size      <= '0;
            r_count     <= '0;
            r_step      <= GROW_STEP_RESET;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= i_cmd.finish;
            if (i_cfg_valid) begin
                r_step <= i_cfg_grow_step;
            end
            // drop slots at and beyond the new size
            if (i_cmd.sweep && (r_ctr >= ns) && r_valid[ctr_a]) begin
                r_valid[ctr_a] <= 1'b0;
                r_count        <= r_count - 1'b1;
            end
            if (i_cmd.finish) begin
                case (r_mode)
                    MODE_INSERT: begin
                        if (!ins_full) begin
                            r_valid[ctr_a] <= 1'b1;
                            r_count        <= r_count + 1'b1;
                            if (!ctr_in_size) begin
                                r_size <= grown_sat;
                            end
                        end
                    end
                    MODE_WRITE, MODE_CHANGE: begin
                        if (idx_in && !idx_was) begin
                            r_valid[idx_a] <= 1'b1;
                            r_count        <= r_count + 1'b1;
                        end
                    end
                    MODE_REMOVE: begin
                        if (idx_was) begin
                            r_valid[idx_a] <= 1'b0;
                            r_count        <= r_count - 1'b1;
                        end
                    end
                    MODE_RESIZE: begin
                        r_size <= ns;
                    end
                    MODE_CLEAR: begin
                        r_valid <= '0;
                        r_size  <= '0;
                        r_count <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        n_res_index  = '0;
        n_res_value  = '0;
        n_res_was    = 1'b0;
        n_res_status = ST_OK;
        case (r_mode)
            MODE_INSERT: begin
                if (ins_full) begin
                    n_res_status = ST_FULL;
                end else begin
                    n_res_index = 6'(r_ctr);
                end
            end
            MODE_WRITE, MODE_CHANGE, MODE_REMOVE, MODE_READ: begin
                if (!idx_in) begin
                    n_res_status = ST_RANGE;
                end else begin
                    n_res_was = idx_was;
                    if ((r_mode inside {MODE_CHANGE, MODE_REMOVE, MODE_READ})
                            && !idx_was) begin
                        n_res_status = ST_UNUSED;
                    end
                    if (r_mode == MODE_READ) begin
                        n_res_value = 32'(r_rd_data);
                    end
                end
            end
            MODE_FIND: begin
                if (hit) begin
                    n_res_index = 6'(r_cmp_addr);
                    n_res_was   = 1'b1;
                end else begin
                    n_res_status = ST_NOT_FOUND;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode     <= i_mode;
            r_idx      <= i_slot_index;
            r_data     <= DATA_WIDTH'(i_data_value);
            r_req      <= i_new_size;
            r_ctr      <= '0;
            r_cmp_live <= 1'b0;
        end else if (i_cmd.step) begin
            r_ctr      <= r_ctr + 1'b1;
            r_cmp_addr <= ctr_a;
            r_cmp_live <= 1'b1;
        end
        if (i_cmd.finish) begin
            r_res_index  <= n_res_index;
            r_res_value  <= n_res_value;
            r_res_was    <= n_res_was;
            r_res_status <= n_res_status;
        end
    end

    assign o_result_valid   = r_res_valid;
    assign o_result_index   = r_res_index;
    assign o_read_value     = r_res_value;
    assign o_slot_was_valid = r_res_was;
    assign o_used_count     = 7'(r_count);
    assign o_size_in_use    = 7'(r_size);
    assign o_status         = r_res_status;

endmodule

>>> sv/slot_table_first_free.sv
// Slot table with a valid bit per slot, a size in use and a count of valid slots.
// Command channel: drive start with mode, slot_index, data_value and new_size; the
// item is taken at a clock edge with start high and busy low. busy stays high while
// the item is worked on.
// Result channel: o_result_valid is high for one cycle, the first cycle with busy
// low, with all result fields; the receiver cannot stall it and must take it then.
// Configuration: i_cfg_valid with i_cfg_grow_step writes the grow step; o_cfg_ready
// is always high. Write it only while the block is idle.
// Per item: write, change, remove and clear pass through state S_ONE; read passes
// through S_READ, for the registered memory read, and S_RDOUT; insert runs to the
// lowest free slot, or to the size when none is free; find runs to a match or the
// size. Insert examines one valid bit a cycle, and find one slot a cycle through the
// single read port of the data memory; resize sweeps every valid bit once.
// A new item may start in the cycle that shows the result of the previous one.
// Reset empties the table (size and count zero, no valid slot) and sets the grow
// step to one; data words are left as they are.
module slot_table_first_free
    import stff_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_mode,
    input  logic [5:0]  i_slot_index,
    input  logic [31:0] i_data_value,
    input  logic [6:0]  i_new_size,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_grow_step,
    output logic        o_result_valid,
    output logic [5:0]  o_result_index,
    output logic [31:0] o_read_value,
    output logic        o_slot_was_valid,
    output logic [6:0]  o_used_count,
    output logic [6:0]  o_size_in_use,
    output logic [2:0]  o_status
);

    t_cmd  cmd;
    t_stat stat;
    t_mode mode;

    assign mode        = t_mode'(i_mode);
    assign o_cfg_ready = 1'b1;

    stff_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_mode  (mode),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    stff_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_mode           (mode),
        .i_slot_index     (i_slot_index),
        .i_data_value     (i_data_value),
        .i_new_size       (i_new_size),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_grow_step  (i_cfg_grow_step),
        .o_result_valid   (o_result_valid),
        .o_result_index   (o_result_index),
        .o_read_value     (o_read_value),
        .o_slot_was_valid (o_slot_was_valid),
        .o_used_count     (o_used_count),
        .o_size_in_use    (o_size_in_use),
        .o_status         (o_status)
    );

endmodule

>>> sv/stff_chk.sv
module stff_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_result_valid,
    input logic [6:0] o_used_count,
    input logic [6:0] o_size_in_use
);

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result shown while busy");

    a_fall_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(busy)) |-> o_result_valid)
        else $error("busy fell without a result");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("two results in consecutive cycles");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_used_count <= o_size_in_use))
        else $error("used count above size");

endmodule

bind slot_table_first_free stff_chk u_chk (.*);
